FILE: sv/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel edge/threshold block.
// ----------------------------------------------------------------------------
package sobel_pkg;

   // configuration register file
   localparam int CFG_W    = 11;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 11'd1024;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 11'd1024;
   localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = 11'd200;

   // input opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // result values
   localparam int              EDGE_W   = 8;
   localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

   // flags that travel with a transaction from the control stage to the kernel
   typedef struct packed {
      logic pix_en;    // real pixel: update window and line buffers
      logic emit;      // transaction produces a result
      logic interior;  // result pixel is off the frame border
      logic last;      // result is the final one of the frame
   } stage_flags_type;

endpackage

FILE: sv/sobel_if.sv
// ----------------------------------------------------------------------------
// sobel_req_if / sobel_rsp_if
// Valid/ready stream channels for pixel input and edge result output.
// ----------------------------------------------------------------------------
interface sobel_req_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output op, output pixel, input ready);
   modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface sobel_rsp_if;
   import sobel_pkg::*;
   logic              valid;
   logic              ready;
   logic [EDGE_W-1:0] edge_value;
   logic              frame_last;

   modport source (output valid, output edge_value, output frame_last, input ready);
   modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

FILE: sv/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector with magnitude threshold.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per clock when req.valid stays high and
// rsp.ready allows; the result of the pixel that completes a window passes
// the stage-1 and result registers, and results trail the input by one row
// plus one pixel. The two previous rows live in one simple dual-port RAM of
// MAX_WIDTH words of 2*PIXEL_BITS bits, read as a pixel is accepted and
// rewritten as it leaves stage 1, so the rate is set by that single read and
// write per column: one item per cycle sustained. Interior pixels give 255
// when |Gx|+|Gy| exceeds edge_threshold, border pixels give 0. After the
// last pixel, flush items (or extra pixels) each drain one result until
// the one flagged frame_last. Writing frame_width or frame_height restarts
// the frame; the line RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   sobel_req_if.sink                     req,
   sobel_rsp_if.source                   rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sobel_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sobel_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sobel_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import sobel_pkg::*;

   localparam int W_W = $clog2(MAX_WIDTH+1);
   localparam int H_W = $clog2(MAX_HEIGHT+1);
   localparam int C_W = $clog2(MAX_WIDTH);

   logic [W_W-1:0]        width_eff;
   logic [H_W-1:0]        height_eff;
   logic [CFG_W-1:0]      threshold;
   logic                  restart;

   logic                  s1_fire;
   logic                  s1_valid;
   stage_flags_type       s1_flags;
   logic [PIXEL_BITS-1:0] s1_pixel;
   logic [C_W-1:0]        s1_col;

   logic                    ram_rd_en;
   logic [C_W-1:0]          ram_rd_addr;
   logic [2*PIXEL_BITS-1:0] ram_rd_data;
   logic                    ram_wr_en;
   logic [C_W-1:0]          ram_wr_addr;
   logic [2*PIXEL_BITS-1:0] ram_wr_data;

   sobel_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .threshold   (threshold),
      .restart     (restart)
   );

   sobel_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .restart    (restart),
      .s1_fire    (s1_fire),
      .s1_valid   (s1_valid),
      .s1_flags   (s1_flags),
      .s1_pixel   (s1_pixel),
      .s1_col     (s1_col),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr)
   );

   sobel_ram #(
      .WIDTH (2*PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sobel_kernel #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_kernel (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_flags    (s1_flags),
      .s1_pixel    (s1_pixel),
      .s1_col      (s1_col),
      .ram_rd_data (ram_rd_data),
      .threshold   (threshold),
      .s1_fire     (s1_fire),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .rsp         (rsp)
   );

`ifndef SYNTHESIS
   // the final result of a frame is always a border pixel
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_last |-> rsp.edge_value == EDGE_OFF)
      else $error("frame_last result carries a nonzero edge value");

   // results are binary
   a_edge_binary: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.edge_value == EDGE_OFF || rsp.edge_value == EDGE_ON))
      else $error("edge value is neither 0 nor 255");

   // line buffer write-back never collides with the read of the next column
   a_ram_no_collide: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("line RAM read and write hit the same column");

   // a real pixel always reads the line RAM in its accepting cycle
   a_window_fed: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> s1_valid && s1_flags.pix_en && $past(ram_rd_en || !s1_fire))
      else $error("window update without line RAM data");
`endif
endmodule

FILE: sv/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sobel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/sobel_csr.sv
// ----------------------------------------------------------------------------
// sobel_csr
// APB register file: frame size and threshold, with size clamping.
// ----------------------------------------------------------------------------
module sobel_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sobel_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [sobel_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [sobel_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                csr_pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
   output logic [sobel_pkg::CFG_W-1:0]         threshold,
   output logic                                restart
);
   import sobel_pkg::*;

   localparam int W_W = $clog2(MAX_WIDTH+1);
   localparam int H_W = $clog2(MAX_HEIGHT+1);

   logic [CFG_W-1:0] width_ff,  width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CFG_W-1:0] thr_ff,    thr_in;
   logic             wr_stb;
   logic [1:0]       reg_idx;
   logic [31:0]      w32, h32;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      restart   = 1'b0;
      if (wr_stb) begin
         case (reg_idx)
            REG_FRAME_WIDTH: begin
               width_in = csr_pwdata[CFG_W-1:0];
               restart  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = csr_pwdata[CFG_W-1:0];
               restart   = 1'b1;
            end
            REG_EDGE_THRESHOLD: begin
               thr_in = csr_pwdata[CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         thr_ff    <= RST_EDGE_THRESHOLD;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DW'(height_ff);
         REG_EDGE_THRESHOLD: csr_prdata = CSR_DW'(thr_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // effective sizes clamp to 3..MAX
   always_comb begin
      w32 = 32'(width_ff);
      if (w32 < 32'd3) begin
         w32 = 32'd3;
      end else if (w32 > 32'(MAX_WIDTH)) begin
         w32 = 32'(MAX_WIDTH);
      end
      h32 = 32'(height_ff);
      if (h32 < 32'd3) begin
         h32 = 32'd3;
      end else if (h32 > 32'(MAX_HEIGHT)) begin
         h32 = 32'(MAX_HEIGHT);
      end
   end

   assign width_eff  = w32[W_W-1:0];
   assign height_eff = h32[H_W-1:0];
   assign threshold  = thr_ff;
endmodule

FILE: sv/sobel_ctrl.sv
// ----------------------------------------------------------------------------
// sobel_ctrl
// Input stage: raster counters, result scheduling and the stage-1 register.
// ----------------------------------------------------------------------------
module sobel_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   sobel_req_if.sink                         req,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_eff,
   input  logic                              restart,
   input  logic                              s1_fire,
   output logic                              s1_valid,
   output sobel_pkg::stage_flags_type        s1_flags,
   output logic [PIXEL_BITS-1:0]             s1_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
   output logic                              rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr
);
   import sobel_pkg::*;

   localparam int W_W  = $clog2(MAX_WIDTH+1);
   localparam int H_W  = $clog2(MAX_HEIGHT+1);
   localparam int C_W  = $clog2(MAX_WIDTH);
   localparam int OR_W = $clog2(MAX_HEIGHT);

   logic [C_W-1:0]  in_col_ff,  in_col_in;
   logic [H_W-1:0]  in_row_ff,  in_row_in;
   logic [C_W-1:0]  out_col_ff, out_col_in;
   logic [OR_W-1:0] out_row_ff, out_row_in;

   logic                  s1_valid_ff, s1_valid_in;
   stage_flags_type       s1_flags_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [C_W-1:0]        s1_col_ff;

   logic            accept;
   logic            all_in;
   logic            pixel_item;
   logic            in_col_wrap;
   logic            out_col_wrap;
   stage_flags_type flags;

   assign req.ready = !s1_valid_ff || s1_fire;
   assign accept    = req.valid && req.ready;

   assign all_in      = in_row_ff >= height_eff;
   assign pixel_item  = (req.op == OP_PIXEL) && !all_in;
   assign in_col_wrap = W_W'(in_col_ff) == (width_eff - W_W'(1));
   assign out_col_wrap = W_W'(out_col_ff) == (width_eff - W_W'(1));

   always_comb begin
      flags.pix_en   = pixel_item;
      // a pixel yields a result once one row plus one pixel has arrived;
      // after the last pixel every item drains one border result
      flags.emit     = pixel_item
                     ? (in_row_ff >= H_W'(2) || (in_row_ff == H_W'(1) && in_col_ff != '0))
                     : all_in;
      flags.interior = pixel_item && in_row_ff >= H_W'(2) && in_col_ff >= C_W'(2);
      flags.last     = out_col_wrap && (H_W'(out_row_ff) == (height_eff - H_W'(1)));
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (pixel_item) begin
            if (in_col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + H_W'(1);
            end else begin
               in_col_in = in_col_ff + C_W'(1);
            end
         end
         if (flags.emit) begin
            if (flags.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OR_W'(1);
            end else begin
               out_col_in = out_col_ff + C_W'(1);
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.ready) begin
         s1_valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
         s1_pixel_ff <= req.pixel;
         s1_col_ff   <= in_col_ff;
      end
   end

   // line buffer column is read as the pixel enters; data lines up with stage 1
   assign rd_en    = accept && pixel_item;
   assign rd_addr  = in_col_ff;

   assign s1_valid = s1_valid_ff;
   assign s1_flags = s1_flags_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_col   = s1_col_ff;
endmodule

FILE: sv/sobel_kernel.sv
// ----------------------------------------------------------------------------
// sobel_kernel
// 3x3 window, Sobel gradient magnitude, threshold and the result register.
// ----------------------------------------------------------------------------
module sobel_kernel #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              s1_valid,
   input  sobel_pkg::stage_flags_type        s1_flags,
   input  logic [PIXEL_BITS-1:0]             s1_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
   input  logic [2*PIXEL_BITS-1:0]           ram_rd_data,
   input  logic [sobel_pkg::CFG_W-1:0]       threshold,
   output logic                              s1_fire,
   output logic                              ram_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]      ram_wr_addr,
   output logic [2*PIXEL_BITS-1:0]           ram_wr_data,
   sobel_rsp_if.source                       rsp
);
   import sobel_pkg::*;

   localparam int P     = PIXEL_BITS;
   localparam int MAG_W = P + 3;
   localparam int CMP_W = (MAG_W > CFG_W) ? MAG_W : CFG_W;

   logic [P-1:0] win_ff [3][2];   // [row][col], col 1 is the newer
   logic [P-1:0] col_new [3];

   logic              out_valid_ff, out_valid_in;
   logic [EDGE_W-1:0] edge_ff;
   logic              last_ff;

   logic              load;
   logic [P+1:0]      gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [P+2:0] gx, gy;
   logic [P+1:0]      ax, ay;
   logic [MAG_W-1:0]  mag;
   logic [EDGE_W-1:0] edge_val;

   assign col_new[0] = ram_rd_data[2*P-1:P];
   assign col_new[1] = ram_rd_data[P-1:0];
   assign col_new[2] = s1_pixel;

   assign s1_fire = s1_valid && (!s1_flags.emit || !out_valid_ff || rsp.ready);
   assign load    = s1_fire && s1_flags.emit;

   // upper row takes the old middle row, middle row takes the new pixel
   assign ram_wr_en   = s1_fire && s1_flags.pix_en;
   assign ram_wr_addr = s1_col;
   assign ram_wr_data = {col_new[1], s1_pixel};

   always_comb begin
      gx_pos = {2'b00, col_new[0]} + {1'b0, col_new[1], 1'b0} + {2'b00, col_new[2]};
      gx_neg = {2'b00, win_ff[0][0]} + {1'b0, win_ff[1][0], 1'b0} + {2'b00, win_ff[2][0]};
      gy_pos = {2'b00, win_ff[0][0]} + {1'b0, win_ff[0][1], 1'b0} + {2'b00, col_new[0]};
      gy_neg = {2'b00, win_ff[2][0]} + {1'b0, win_ff[2][1], 1'b0} + {2'b00, col_new[2]};
      gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      ax = gx[P+2] ? (P+2)'(-gx) : gx[P+1:0];
      ay = gy[P+2] ? (P+2)'(-gy) : gy[P+1:0];
      mag = {1'b0, ax} + {1'b0, ay};
      edge_val = EDGE_OFF;
      if (s1_flags.interior && (CMP_W'(mag) > CMP_W'(threshold))) begin
         edge_val = EDGE_ON;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= col_new[r];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         edge_ff <= edge_val;
         last_ff <= s1_flags.last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.edge_value = edge_ff;
   assign rsp.frame_last = last_ff;
endmodule

FILE: sim/tb_sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold
// Self-checking testbench of the streaming Sobel edge/threshold block.
// ----------------------------------------------------------------------------
// A short directed sequence runs one 3x3 frame with borders, a strong edge
// in the center, early flushes and surplus pixels. Two clamped frames follow,
// cut short by the next size write: one wider than the maximum, one narrower
// than three. Random frames come last: small sizes, thresholds at both ends,
// frames cut short by a size write, and random gaps on the pixel side and
// stalls on the result side. A predictor in this file runs on every accepted
// input transaction and queues the expected results. The monitor compares
// each result transaction, field by field, with the oldest queued result.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold;
   import sobel_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_W         = 1024;
   localparam int          MAX_H         = 1024;
   localparam int          PIXEL_BITS    = 8;
   localparam int unsigned RANDOM_ITEMS  = 300;
   localparam int unsigned WIDE_ITEMS    = 1030;
   localparam int unsigned TALL_ITEMS    = 40;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned NO_STOP       = 32'hFFFF_FFFF;
   localparam int          DIR_STEPS     = 18;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_value;
      logic              frame_last;
   } edge_result_type;

   // one row of the directed sequence: either a register write or an item
   typedef struct packed {
      logic             is_write;
      logic [1:0]       reg_idx;
      logic [CFG_W-1:0] reg_val;
      logic             op;
      logic [7:0]       pixel;
      logic             typed;
      edge_result_type  typed_res;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_AW-1:0]  csr_paddr;
   logic [CSR_DW-1:0]  csr_pwdata;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   sobel_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_ch ();
   sobel_rsp_if                            rsp_ch ();

   sobel_edge_threshold #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H),
      .PIXEL_BITS (PIXEL_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor state
   // ------------------------------------------------------------------------
   logic [CFG_W-1:0] cfg_width     = RST_FRAME_WIDTH;
   logic [CFG_W-1:0] cfg_height    = RST_FRAME_HEIGHT;
   logic [CFG_W-1:0] cfg_threshold = RST_EDGE_THRESHOLD;
   logic [7:0]       upper_line [0:MAX_W-1];
   logic [7:0]       middle_line [0:MAX_W-1];
   int               win [3][3];
   int unsigned      in_col;
   int unsigned      in_row;
   int unsigned      out_count;

   edge_result_type pending_edges [$];
   int unsigned     mismatch_count = 0;
   int unsigned     random_items   = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     stall_left     = 0;
   bit              source_gaps    = 1'b1;
   bit              sink_stalls    = 1'b1;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic void restart_frame();
      foreach (win[a, b]) win[a][b] = 0;
      in_col    = 0;
      in_row    = 0;
      out_count = 0;
   endfunction

   // next result in raster order; the frame closes on its last one
   function automatic edge_result_type next_output(input logic [7:0] v,
                                                   input int unsigned total);
      edge_result_type res;
      res.edge_value = v;
      res.frame_last = (out_count + 1 >= total);
      if (res.frame_last) restart_frame();
      else out_count++;
      return res;
   endfunction

   function automatic bit predict_edge(input logic op, input logic [7:0] px,
                                       output edge_result_type res);
      int unsigned w, h, c, r;
      int          gx, gy, mag;
      logic [7:0]  val;
      w   = clamp_dim(cfg_width, MAX_W);
      h   = clamp_dim(cfg_height, MAX_H);
      res = '0;
      // flush ticks and surplus pixels drain the tail; before that, flush is a no-op
      if (op == OP_FLUSH || in_row >= h) begin
         if (in_row < h) return 1'b0;
         res = next_output(EDGE_OFF, w * h);
         return 1'b1;
      end
      c = in_col;
      r = in_row;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2]      = int'(upper_line[c]);
      win[1][2]      = int'(middle_line[c]);
      win[2][2]      = int'(px);
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      // the last result never falls on a pixel, so the counters move first
      in_col = c + 1;
      if (in_col >= w) begin
         in_col = 0;
         in_row = r + 1;
      end
      if (r * w + c < w + 1) return 1'b0;
      val = EDGE_OFF;
      if (r >= 2 && c >= 2) begin
         gx  = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
         gy  = (win[0][0] + 2 * win[0][1] + win[0][2]) - (win[2][0] + 2 * win[2][1] + win[2][2]);
         mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         if (mag > int'(cfg_threshold)) val = EDGE_ON;
      end
      res = next_output(val, w * h);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // upper data bits are random and must be ignored
      csr_pwdata  <= {(CSR_DW - CFG_W)'($urandom_range(0, (1 << (CSR_DW - CFG_W)) - 1)), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH: begin
            cfg_width = val;
            restart_frame();
         end
         REG_FRAME_HEIGHT: begin
            cfg_height = val;
            restart_frame();
         end
         REG_EDGE_THRESHOLD: cfg_threshold = val;
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic op, input logic [7:0] px, input bit typed,
                            input edge_result_type typed_res, output bit frame_done);
      edge_result_type res;
      frame_done = 1'b0;
      if (source_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_edge(op, px, res)) begin
         if (typed) res = typed_res;
         pending_edges.push_back(res);
         frame_done = res.frame_last;
      end
   endtask

   // block is idle once every result is in and the pipeline has settled
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // items of the current frame until it closes or stop_after items went out
   task automatic run_segment(input int unsigned stop_after, input int unsigned style);
      int unsigned sent;
      bit          frame_done;
      logic [7:0]  px;
      sent       = 0;
      frame_done = 1'b0;
      while (!frame_done && sent < stop_after) begin
         if (in_row < clamp_dim(cfg_height, MAX_H)) begin
            if ($urandom_range(0, 15) == 0) begin
               // early flush: ignored by the block
               send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0, frame_done);
            end else begin
               case (style)
                  0: px = 8'($urandom_range(0, 255));
                  1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                  2: px = 8'd100 + 8'($urandom_range(0, 24));
                  default: px = 8'($urandom_range(0, 15));
               endcase
               send_item(OP_PIXEL, px, 1'b0, '0, frame_done);
               sent++;
            end
         end else begin
            send_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, 8'($urandom_range(0, 255)),
                      1'b0, '0, frame_done);
            sent++;
         end
      end
      random_items += sent;
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 7);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_edges.size() == 0) begin
            flag_mismatch("result with nothing pending", -1, int'(rsp_ch.edge_value));
         end else begin
            want = pending_edges.pop_front();
            if (rsp_ch.edge_value !== want.edge_value)
               flag_mismatch("edge_value", int'(want.edge_value), int'(rsp_ch.edge_value));
            if (rsp_ch.frame_last !== want.frame_last)
               flag_mismatch("frame_last", int'(want.frame_last), int'(rsp_ch.frame_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // directed sequence: 3x3 frame, strong edge at the center pixel
   // ------------------------------------------------------------------------
   step_row_type dir_steps [0:DIR_STEPS-1] = '{
      '{1'b1, REG_FRAME_WIDTH,  11'd3, OP_PIXEL, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b1, REG_FRAME_HEIGHT, 11'd3, OP_PIXEL, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_FLUSH, 8'd255, 1'b0, '{EDGE_OFF, 1'b0}},  // early flush
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd255, 1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd128, 1'b1, '{EDGE_OFF, 1'b0}},  // first border result
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd255, 1'b1, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd0,   1'b1, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_FLUSH, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}},  // early flush
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd255, 1'b1, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd255, 1'b0, '{EDGE_OFF, 1'b0}},  // center pixel
      '{1'b0, 2'd0, 11'd0, OP_FLUSH, 8'd0,   1'b1, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd255, 1'b1, '{EDGE_OFF, 1'b0}},  // surplus pixel
      '{1'b0, 2'd0, 11'd0, OP_FLUSH, 8'd0,   1'b1, '{EDGE_OFF, 1'b0}},
      '{1'b0, 2'd0, 11'd0, OP_PIXEL, 8'd0,   1'b1, '{EDGE_OFF, 1'b1}},  // frame end
      '{1'b0, 2'd0, 11'd0, OP_FLUSH, 8'd0,   1'b0, '{EDGE_OFF, 1'b0}}   // next frame, early
   };

   initial begin
      int unsigned      pick;
      int unsigned      stop_after;
      bit               tail_part;
      bit               frame_done;
      bit               size_write;
      bit               thr_write;
      logic [CFG_W-1:0] w_pick;
      logic [CFG_W-1:0] h_pick;
      logic [CFG_W-1:0] thr_pick;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op    = OP_PIXEL;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      foreach (upper_line[k]) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
      restart_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_STEPS; i++) begin
         if (dir_steps[i].is_write) begin
            wait_idle();
            csr_write(dir_steps[i].reg_idx, dir_steps[i].reg_val);
         end else begin
            send_item(dir_steps[i].op, dir_steps[i].pixel, dir_steps[i].typed,
                      dir_steps[i].typed_res, frame_done);
         end
      end

      // widest frame: width above range clamps to the maximum; the first row
      // wraps and the first results come out before the frame is cut short
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 11'd2047);
      csr_write(REG_FRAME_HEIGHT, 11'd3);
      csr_write(REG_EDGE_THRESHOLD, 11'd300);
      run_segment(WIDE_ITEMS, 0);

      // tall frame: width below range clamps to three
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 11'd1);
      csr_write(REG_FRAME_HEIGHT, 11'd1024);
      csr_write(REG_EDGE_THRESHOLD, 11'd0);
      run_segment(TALL_ITEMS, 3);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         tail_part   = (random_items >= RANDOM_ITEMS * 4 / 5);
         // the cut-short tall frame must not carry on into the random part
         size_write  = !tail_part && (random_items == 0 || $urandom_range(0, 3) != 0);
         thr_write   = !tail_part && ($urandom_range(0, 1) != 0);
         if (size_write || thr_write) wait_idle();
         source_gaps = !tail_part && ($urandom_range(0, 3) != 0);
         sink_stalls = !tail_part && ($urandom_range(0, 3) != 0);
         // without a size write an unfinished frame simply carries on
         if (size_write) begin
            case ($urandom_range(0, 9))
               0:       pick = $urandom_range(0, 2);
               1:       pick = $urandom_range(13, 40);
               default: pick = $urandom_range(3, 12);
            endcase
            w_pick = pick[CFG_W-1:0];
            pick   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            h_pick = pick[CFG_W-1:0];
            csr_write(REG_FRAME_WIDTH, w_pick);
            csr_write(REG_FRAME_HEIGHT, h_pick);
         end
         if (thr_write) begin
            case ($urandom_range(0, 7))
               0:       pick = 0;
               1:       pick = 2040;
               2:       pick = 2047;
               3:       pick = $urandom_range(0, 2047);
               default: pick = $urandom_range(0, 700);
            endcase
            thr_pick = pick[CFG_W-1:0];
            csr_write(REG_EDGE_THRESHOLD, thr_pick);
         end
         stop_after = ($urandom_range(0, 5) == 0) ?
                      $urandom_range(1, 3 * clamp_dim(cfg_width, MAX_W)) : NO_STOP;
         run_segment(stop_after, $urandom_range(0, 3));
      end

      req_ch.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
